/* src/skh_pkg.sv */
// ---------------------------------------------------------------------------
// String key hash package
// Shared types, register indexes and hash constants of the string key hash
// engine.
// ---------------------------------------------------------------------------
package skh_pkg;

  // Configuration register indexes.
  localparam logic CfgFinalizerMode = 1'b0;
  localparam logic CfgSignedChars   = 1'b1;

  // Finalizer codes.
  localparam logic FinKnuth   = 1'b0;
  localparam logic FinJenkins = 1'b1;

  // Width of one per-byte term: 2*x*x - x + 3 always lies in [3, 2^17).
  localparam int TermW = 17;

  // Queue between the front and back parts.
  localparam int QDepth = 4;
  localparam int QIdxW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Knuth multiplicative constant.
  localparam logic [31:0] KnuthMult = 32'd2654435761;

  // Jenkins 32-bit mix constants and last step index.
  localparam logic [31:0] JenkinsC0 = 32'h7ed55d16;
  localparam logic [31:0] JenkinsC1 = 32'hc761c23c;
  localparam logic [31:0] JenkinsC2 = 32'h165667b1;
  localparam logic [31:0] JenkinsC3 = 32'hd3a2646c;
  localparam logic [31:0] JenkinsC4 = 32'hfd7046c5;
  localparam logic [31:0] JenkinsC5 = 32'hb55a4f09;
  localparam logic [2:0]  JenkinsLastStep = 3'd5;

  // One classified request as it travels from front to back.
  typedef struct packed {
    logic [TermW-1:0] term;
    logic             key_end;
  } skh_entry_t;

  // One step of the Jenkins 32-bit integer mix.
  function automatic logic [31:0] jenkins_step(input logic [2:0] idx,
                                               input logic [31:0] v);
    logic [31:0] r;
    r = v;
    unique case (idx)
      3'd0:    r = (v + JenkinsC0) + (v << 12);
      3'd1:    r = (v ^ JenkinsC1) ^ (v >> 19);
      3'd2:    r = (v + JenkinsC2) + (v << 5);
      3'd3:    r = (v + JenkinsC3) ^ (v << 9);
      3'd4:    r = (v + JenkinsC4) + (v << 3);
      3'd5:    r = (v ^ JenkinsC5) ^ (v >> 16);
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

/* src/string_key_hash_engine_unit.sv */
// ---------------------------------------------------------------------------
// String key hash engine
// Hashes a key arriving one byte per request and emits a 32-bit hash.
// ---------------------------------------------------------------------------
// Each byte request adds 2*x*x - x + 3 to a 32-bit running sum; a zero byte or
// a request marked last ends the key, and the selected finalizer (Knuth
// multiplicative or Jenkins 32-bit mix) produces the hash. The front part
// computes the byte's term and classifies it in the cycle of acceptance and
// writes it to a four-entry queue, so bytes are accepted one per cycle while
// the queue has room. The back part takes one non-terminating byte per cycle;
// a terminating request holds it in the mix state, which performs the 32x32
// multiply with the Knuth finalizer or the six mix steps in turn with the
// Jenkins mix, and leaves once the output is free. A finished hash waits in
// an output register while the next key's bytes keep flowing into the queue.
module string_key_hash_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  logic                finalizer_mode_q;
  logic                signed_chars_q;
  skh_pkg::skh_entry_t front_entry;
  skh_pkg::skh_entry_t q_entry;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  logic                push;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finalizer_mode_q <= skh_pkg::FinKnuth;
      signed_chars_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        skh_pkg::CfgFinalizerMode: finalizer_mode_q <= cfg_data_i;
        skh_pkg::CfgSignedChars:   signed_chars_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Accept a request whenever the queue has room.
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  skh_front u_front (
    .signed_chars_i (signed_chars_q),
    .char_byte_i    (char_byte_i),
    .last_i         (last_i),
    .entry_o        (front_entry)
  );

  skh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (front_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .entry_o      (q_entry)
  );

  skh_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .finalizer_mode_i (finalizer_mode_q),
    .q_valid_i        (q_valid),
    .q_entry_i        (q_entry),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hash_value_o     (hash_value_o)
  );

endmodule

/* src/skh_front.sv */
// ---------------------------------------------------------------------------
// String key hash front part
// Classifies each incoming character and computes its polynomial term.
// ---------------------------------------------------------------------------
module skh_front (
  input  logic              signed_chars_i,
  input  logic [7:0]        char_byte_i,
  input  logic              last_i,
  output skh_pkg::skh_entry_t entry_o
);

  logic signed [8:0]  x;
  logic signed [17:0] sq;
  logic signed [18:0] t;
  logic               is_zero;

  // Extend the byte as signed or unsigned, then form 2*x*x - x + 3.
  always_comb begin
    x       = $signed({signed_chars_i & char_byte_i[7], char_byte_i});
    sq      = x * x;
    t       = (19'(sq) <<< 1) - 19'(x) + 19'sd3;
    is_zero = (char_byte_i == 8'd0);
  end

  // A zero byte contributes nothing and ends the key, as does a last marker.
  always_comb begin
    entry_o.term    = is_zero ? '0 : t[skh_pkg::TermW-1:0];
    entry_o.key_end = is_zero | last_i;
  end

endmodule

/* src/skh_queue.sv */
// ---------------------------------------------------------------------------
// String key hash queue
// Short FIFO that decouples the front part from the back part.
// ---------------------------------------------------------------------------
module skh_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  skh_pkg::skh_entry_t push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output skh_pkg::skh_entry_t entry_o
);

  skh_pkg::skh_entry_t          mem_q [skh_pkg::QDepth];
  logic [skh_pkg::QIdxW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [skh_pkg::QCntW-1:0]    count_q;

  assign full_o  = (count_q == skh_pkg::QCntW'(skh_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // The fill count never exceeds the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= skh_pkg::QCntW'(skh_pkg::QDepth))
    else $error("queue count above depth");

  // Nothing is pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  // Nothing is popped from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

/* src/skh_back.sv */
// ---------------------------------------------------------------------------
// String key hash back part
// Accumulates terms, runs the selected finalizer and holds the result.
// ---------------------------------------------------------------------------
module skh_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                finalizer_mode_i,
  input  logic                q_valid_i,
  input  skh_pkg::skh_entry_t q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         hash_value_o
);

  typedef enum logic {
    B_IDLE,
    B_MIX
  } back_state_e;

  back_state_e  state_q;
  logic [31:0]  sum_q;
  logic [31:0]  v_q;
  logic [2:0]   step_q;
  logic         mode_q;
  logic         out_valid_q;
  logic [31:0]  hash_q;

  logic [31:0]  sum_plus;
  logic [31:0]  result;
  logic         mix_last;
  logic         out_free;

  // Pop only while no key is being finalized.
  always_comb begin
    q_pop_o  = (state_q == B_IDLE) && q_valid_i;
    sum_plus = sum_q + 32'(q_entry_i.term);
    mix_last = (mode_q == skh_pkg::FinKnuth) || (step_q == skh_pkg::JenkinsLastStep);
    result   = (mode_q == skh_pkg::FinKnuth) ? v_q * skh_pkg::KnuthMult
                                            : skh_pkg::jenkins_step(step_q, v_q);
    out_free = !out_valid_q || !out_stall_i;
  end

  // Sequencer: accumulate, then finalize one mix step per cycle, holding the last until the output is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      sum_q       <= '0;
      v_q         <= '0;
      step_q      <= '0;
      mode_q      <= skh_pkg::FinKnuth;
      out_valid_q <= 1'b0;
      hash_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (q_pop_o) begin
            if (q_entry_i.key_end) begin
              v_q     <= sum_plus;
              sum_q   <= '0;
              step_q  <= '0;
              mode_q  <= finalizer_mode_i;
              state_q <= B_MIX;
            end else begin
              sum_q <= sum_plus;
            end
          end
        end
        B_MIX: begin
          if (!mix_last) begin
            v_q    <= result;
            step_q <= step_q + 3'd1;
          end else if (out_free) begin
            hash_q      <= result;
            out_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  // A key end clears the accumulator and starts finalizing.
  a_key_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_entry_i.key_end) |=> (sum_q == '0) && (state_q == B_MIX))
    else $error("key end did not clear the sum");

  // The mix step counter stays within the Jenkins step range.
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_MIX) |-> (step_q <= skh_pkg::JenkinsLastStep))
    else $error("mix step out of range");

  // A Knuth finalize that finds the output free returns to idle with the hash valid in the next cycle.
  a_knuth_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_MIX && mode_q == skh_pkg::FinKnuth && out_free)
    |=> (state_q == B_IDLE) && out_valid_q)
    else $error("Knuth finalize did not complete");

endmodule

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// String key hash engine testbench
// Streams key bytes into the engine under every register setting. A local
// model predicts each hash, and the monitor compares the hashes against it.
// ---------------------------------------------------------------------------
// A queue of pending key bytes feeds the request driver, which works on the
// falling edge. The monitor samples both handshakes on the rising edge. It
// advances the local model on each accepted request and checks each accepted
// hash against the oldest predicted one. Both sides idle at random except in
// the calm stretches.
module testbench;

  // One key byte waiting to be sent.
  typedef struct packed {
    logic [7:0] ch;
    logic       ends;
  } key_char_t;

  localparam int PeriodT   = 12;
  localparam int SettleCyc = 30;
  localparam int IdlePct   = 20;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = skh_pkg::CfgFinalizerMode;
  logic        cfg_data_i  = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_byte_i = 8'h00;
  logic        last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] hash_value_o;

  // Testbench state.
  key_char_t   key_chars[$];
  logic [31:0] hash_fifo[$];
  logic        req_busy    = 1'b0;
  logic        calm        = 1'b0;
  int          err_cnt     = 0;
  int          phase_items = 0;

  // Local copy of the engine state and registers.
  logic [31:0] key_sum  = 32'd0;
  logic        fin_sel  = skh_pkg::FinKnuth;
  logic        sign_sel = 1'b1;

  string_key_hash_engine_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_byte_i  (char_byte_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

  // Clock generation.
  initial begin
    forever #(PeriodT / 2) clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #(PeriodT * 1000000);
    $display("testbench: FAIL");
    $finish;
  end

  // Polynomial term of one byte, read as signed or unsigned.
  function automatic logic [31:0] char_term(input logic [7:0] ch, input logic as_signed);
    logic [31:0] x;
    x = as_signed ? {{24{ch[7]}}, ch} : {24'd0, ch};
    return x * x * 32'd2 - x + 32'd3;
  endfunction

  // Final mix of a completed key sum.
  function automatic logic [31:0] finish_hash(input logic [31:0] v, input logic mode);
    logic [31:0] m;
    if (mode == skh_pkg::FinKnuth) begin
      return v * skh_pkg::KnuthMult;
    end
    m = (v + skh_pkg::JenkinsC0) + (v << 12);
    m = (m ^ skh_pkg::JenkinsC1) ^ (m >> 19);
    m = (m + skh_pkg::JenkinsC2) + (m << 5);
    m = (m + skh_pkg::JenkinsC3) ^ (m << 9);
    m = (m + skh_pkg::JenkinsC4) + (m << 3);
    m = (m ^ skh_pkg::JenkinsC5) ^ (m >> 16);
    return m;
  endfunction

  // Request driver: presents the next pending byte unless idling.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
      if (!req_busy) begin
        if (key_chars.size() > 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid_i  <= 1'b1;
          char_byte_i <= key_chars[0].ch;
          last_i      <= key_chars[0].ends;
          req_busy    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: tracks register writes and requests, and checks each hash.
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (!rst_ni) begin
      key_sum  = 32'd0;
      fin_sel  = skh_pkg::FinKnuth;
      sign_sel = 1'b1;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == skh_pkg::CfgFinalizerMode) begin
          fin_sel = cfg_data_i;
        end else begin
          sign_sel = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        req_busy <= 1'b0;
        void'(key_chars.pop_front());
        if (char_byte_i != 8'h00) begin
          key_sum = key_sum + char_term(char_byte_i, sign_sel);
        end
        if (char_byte_i == 8'h00 || last_i) begin
          hash_fifo.push_back(finish_hash(key_sum, fin_sel));
          key_sum = 32'd0;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (hash_fifo.size() == 0) begin
          $display("%0t: unexpected hash: expected none, actual %h", $time, hash_value_o);
          err_cnt++;
        end else begin
          want = hash_fifo.pop_front();
          if (hash_value_o !== want) begin
            $display("%0t: hash_value mismatch: expected %h, actual %h",
                     $time, want, hash_value_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // Queue one key byte.
  task automatic push_char(input logic [7:0] ch, input logic ends);
    key_char_t kc;
    kc.ch   = ch;
    kc.ends = ends;
    key_chars.push_back(kc);
    phase_items++;
  endtask

  // Random nonzero byte, weighted toward the extremes.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 8'h80;
      1:       return 8'hff;
      2:       return 8'h7f;
      3:       return 8'h01;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Queue one key of random length with a random kind of end.
  task automatic push_key(input int max_len);
    int len;
    int kind;
    len  = $urandom_range(0, max_len);
    kind = $urandom_range(0, 4);
    for (int i = 0; i < len; i++) begin
      push_char(pick_char(), 1'b0);
    end
    case (kind)
      0, 1:    push_char(8'h00, 1'b0);
      2, 3:    push_char(pick_char(), 1'b1);
      default: push_char(8'h00, 1'b1);
    endcase
  endtask

  // Wait until every request is taken, every hash has come and the engine
  // has had time to settle.
  task automatic drain();
    while (key_chars.size() > 0 || req_busy) begin
      @(negedge clk_i);
    end
    while (hash_fifo.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // Register write, only while the engine is idle.
  task automatic write_reg(input logic idx, input logic val);
    @(negedge clk_i);
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    cfg_we_i   <= 1'b1;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Random keys up to a rough number of bytes.
  task automatic random_phase(input int n_items);
    phase_items = 0;
    while (phase_items < n_items) begin
      push_key(($urandom_range(0, 19) == 0) ? 40 : 10);
    end
  endtask

  // Stimulus sequence.
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed keys with the reset setting: Knuth, signed bytes.
    push_char(8'h00, 1'b0);
    push_char(8'h00, 1'b1);
    push_char(8'h01, 1'b1);
    push_char(8'hff, 1'b0);
    push_char(8'h80, 1'b0);
    push_char(8'h7f, 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'h41, 1'b0);
    push_char(8'h42, 1'b1);
    drain();

    // Signed reading changes inside a key.
    push_char(8'hff, 1'b0);
    drain();
    write_reg(skh_pkg::CfgSignedChars, 1'b0);
    push_char(8'hff, 1'b1);
    drain();

    // The finalizer changes inside a key and applies at its end.
    push_char(8'h80, 1'b0);
    drain();
    write_reg(skh_pkg::CfgFinalizerMode, skh_pkg::FinJenkins);
    push_char(8'h00, 1'b0);
    push_char(8'h00, 1'b1);
    push_char(8'hff, 1'b0);
    push_char(8'h80, 1'b1);
    push_char(8'h7f, 1'b0);
    push_char(8'h01, 1'b0);
    push_char(8'h00, 1'b0);
    drain();

    // Random keys under the Jenkins finalizer with unsigned, then signed bytes.
    random_phase(300);
    drain();
    write_reg(skh_pkg::CfgSignedChars, 1'b1);
    random_phase(300);
    drain();

    // No idling on either side in this stretch.
    calm = 1'b1;
    write_reg(skh_pkg::CfgFinalizerMode, skh_pkg::FinKnuth);
    random_phase(300);
    drain();

    // A long unsigned key of 0xff bytes sent back to back.
    write_reg(skh_pkg::CfgSignedChars, 1'b0);
    for (int i = 0; i < 99; i++) begin
      push_char(8'hff, 1'b0);
    end
    push_char(8'hff, 1'b1);
    drain();
    calm = 1'b0;

    // The sender stops halfway until every hash has come.
    random_phase(150);
    drain();
    random_phase(150);
    drain();

    // Random settings for the rest.
    for (int p = 0; p < 3; p++) begin
      write_reg(skh_pkg::CfgFinalizerMode, 1'($urandom_range(0, 1)));
      write_reg(skh_pkg::CfgSignedChars, 1'($urandom_range(0, 1)));
      random_phase(200);
      drain();
    end

    if (err_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
